FILE: rtl/core/gaussian_blur_3x3_stream_top_defines.svh
// assertion macros shared by the blur core modules
// no dependencies; taken in by `include where checks are written
`ifndef GAUSSIAN_BLUR_3X3_STREAM_TOP_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_STREAM_TOP_DEFINES_SVH

// condition that holds on every clock edge out of reset
`define GBL_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define GBL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/gbl_pkg.sv
// types, constants and helpers for the 3x3 gaussian blur stream core
// no dependencies; used by every module of the core
`default_nettype none

package gbl_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int PIX_W        = 8;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 12;
   localparam int ROW_W        = HEIGHT_REG_W + 1;
   localparam int SUM_W        = PIX_W + 4;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = HEIGHT_REG_W;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd480;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_in;
      logic             drain;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] blurred;
      logic             changed;
      logic             any_changed;
      logic             last;
   } rsp_type;

   // one window column, rows top to bottom
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } pix_col_type;

   // which sides of the neighbourhood fall outside the image
   typedef struct packed {
      logic top_out;
      logic bot_out;
      logic left_out;
      logic right_out;
   } border_type;

   typedef struct packed {
      pix_col_type left;
      pix_col_type centre;
      pix_col_type right;
   } nbhd_type;

   // one line store entry: rows two above and one above
   typedef struct packed {
      logic [PIX_W-1:0] above2;
      logic [PIX_W-1:0] above1;
   } line_pair_type;

   function automatic pix_col_type replace_col(input pix_col_type c,
                                               input logic [PIX_W-1:0] centre,
                                               input logic top_out,
                                               input logic bot_out,
                                               input logic col_out);
      pix_col_type r;
      r.top = (top_out || col_out) ? centre : c.top;
      r.mid = col_out ? centre : c.mid;
      r.bot = (bot_out || col_out) ? centre : c.bot;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gbl_line_store.sv
// two line stores kept side by side in one memory, registered read
// depends on gbl_pkg
`default_nettype none

module gbl_line_store (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [gbl_pkg::COL_W-1:0]   wr_addr,
   input  wire gbl_pkg::line_pair_type      wr_data,
   input  wire logic                        rd_en,
   input  wire logic [gbl_pkg::COL_W-1:0]   rd_addr,
   output gbl_pkg::line_pair_type           rd_data
);

   gbl_pkg::line_pair_type store_ff [0:gbl_pkg::MAX_WIDTH-1];
   gbl_pkg::line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/gbl_col_cell.sv
// one column cell of the 3x3 window: holds a column, passes it on when shifted
// and gives its column with outside pixels replaced by the centre; uses gbl_pkg
`default_nettype none

module gbl_col_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        shift_en,
   input  wire gbl_pkg::pix_col_type        col_in,
   input  wire logic [gbl_pkg::PIX_W-1:0]   centre,
   input  wire gbl_pkg::border_type         border,
   input  wire logic                        col_out,
   output gbl_pkg::pix_col_type             nbr_out,
   output gbl_pkg::pix_col_type             tap_out
);

   gbl_pkg::pix_col_type col_ff;
   gbl_pkg::pix_col_type col_in_sel;

   assign col_in_sel = shift_en ? col_in : col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in_sel;
      end
   end

   assign nbr_out = col_ff;
   assign tap_out = gbl_pkg::replace_col(col_ff, centre, border.top_out,
                                         border.bot_out, col_out);

endmodule

`default_nettype wire

FILE: rtl/core/gbl_kernel.sv
// weighted 1 2 1 / 2 4 2 / 1 2 1 sum of a neighbourhood, divided by 16
// depends on gbl_pkg
`default_nettype none

module gbl_kernel (
   input  wire gbl_pkg::nbhd_type           nbhd,
   output logic [gbl_pkg::PIX_W-1:0]        blurred,
   output logic                             changed
);

   logic [gbl_pkg::SUM_W-1:0] corner_sum;
   logic [gbl_pkg::SUM_W-1:0] side_sum;
   logic [gbl_pkg::SUM_W-1:0] total;

   always_comb begin
      corner_sum = gbl_pkg::SUM_W'(nbhd.left.top) + gbl_pkg::SUM_W'(nbhd.right.top)
                 + gbl_pkg::SUM_W'(nbhd.left.bot) + gbl_pkg::SUM_W'(nbhd.right.bot);
      side_sum   = gbl_pkg::SUM_W'(nbhd.centre.top) + gbl_pkg::SUM_W'(nbhd.centre.bot)
                 + gbl_pkg::SUM_W'(nbhd.left.mid) + gbl_pkg::SUM_W'(nbhd.right.mid);
      total      = corner_sum + {side_sum[gbl_pkg::SUM_W-2:0], 1'b0}
                 + {2'b00, nbhd.centre.mid, 2'b00};
      // truncating divide by 16
      blurred    = total[gbl_pkg::SUM_W-1:4];
      changed    = blurred != nbhd.centre.mid;
   end

endmodule

`default_nettype wire

FILE: rtl/core/gaussian_blur_3x3_stream_top.sv
// 3x3 gaussian blur stream: a result, if any, passes s1_ff, s2_nbhd_ff and
// rsp_ff after the transaction filling its window; a pixel's result comes image_width
// + 1 transactions after it. One transaction per cycle unless stalled, set by
// the single line store port pair. Reset (synchronous) sets 640 x 480 and
// clears positions, window and valid bits; line stores are not cleared.
`default_nettype none
`include "gaussian_blur_3x3_stream_top_defines.svh"

module gaussian_blur_3x3_stream_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire gbl_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output gbl_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_write_en,
   input  wire logic [gbl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [gbl_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   typedef struct packed {
      logic [gbl_pkg::PIX_W-1:0] pix;
      logic [gbl_pkg::COL_W-1:0] col;
      logic                      row_ge1;
      logic                      row_ge2;
      logic                      emit;
      logic                      last;
      gbl_pkg::border_type       border;
   } stage1_type;

   logic [gbl_pkg::WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [gbl_pkg::HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [gbl_pkg::WIDTH_REG_W-1:0]  csr_width;
   logic [gbl_pkg::HEIGHT_REG_W-1:0] csr_height;
   logic [gbl_pkg::COL_W-1:0]        col_ff, col_in;
   logic [gbl_pkg::ROW_W-1:0]        row_ff, row_in;

   logic                             adv;
   logic                             drain_row;
   logic                             take;
   logic [gbl_pkg::WIDTH_REG_W-1:0]  col_wide;
   logic                             col_wrap;
   logic [gbl_pkg::ROW_W-1:0]        h_plus1;
   logic                             is_edge;
   logic                             is_main;
   logic                             last_tick;

   stage1_type                       s1_ff, s1_in;
   logic                             s1_valid_ff;
   logic                             fwd_ff, fwd_in;
   gbl_pkg::line_pair_type           fwd_data_ff;
   gbl_pkg::line_pair_type           rd_data;
   gbl_pkg::line_pair_type           wr_data;
   logic [gbl_pkg::PIX_W-1:0]        line_a;
   logic [gbl_pkg::PIX_W-1:0]        line_b;
   gbl_pkg::pix_col_type             new_col;
   logic                             shift_en;

   gbl_pkg::pix_col_type             centre_nbr;
   gbl_pkg::pix_col_type             left_nbr;
   gbl_pkg::pix_col_type             centre_tap;
   gbl_pkg::pix_col_type             left_tap;
   gbl_pkg::nbhd_type                nbhd;

   logic                             s2_valid_ff;
   logic                             s2_last_ff;
   gbl_pkg::nbhd_type                s2_nbhd_ff;
   logic [gbl_pkg::PIX_W-1:0]        blurred;
   logic                             changed;

   logic                             rsp_valid_ff;
   gbl_pkg::rsp_type                 rsp_ff;
   logic                             frame_changed_ff, frame_changed_in;
   logic                             frame_any;

   // ---------------- configuration ----------------
   always_comb begin
      csr_width  = csr_wdata[gbl_pkg::WIDTH_REG_W-1:0];
      csr_height = csr_wdata[gbl_pkg::HEIGHT_REG_W-1:0];
      width_in   = width_ff;
      height_in  = height_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            gbl_pkg::CSR_IMAGE_WIDTH: begin
               if (csr_width == '0) begin
                  width_in = gbl_pkg::WIDTH_REG_W'(1);
               end else if (csr_width > gbl_pkg::WIDTH_REG_W'(gbl_pkg::MAX_WIDTH)) begin
                  width_in = gbl_pkg::WIDTH_REG_W'(gbl_pkg::MAX_WIDTH);
               end else begin
                  width_in = csr_width;
               end
            end
            gbl_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = (csr_height == '0) ? gbl_pkg::HEIGHT_REG_W'(1) : csr_height;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gbl_pkg::WIDTH_RESET;
         height_ff <= gbl_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // ---------------- input position ----------------
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      h_plus1   = {1'b0, height_ff} + gbl_pkg::ROW_W'(1);
      drain_row = row_ff >= {1'b0, height_ff};
      take      = req_valid && adv && (drain_row ? req_data.drain : !req_data.drain);
      col_wide  = {1'b0, col_ff} + gbl_pkg::WIDTH_REG_W'(1);
      col_wrap  = col_wide == width_ff;
      is_edge   = (col_ff == '0) && (row_ff >= gbl_pkg::ROW_W'(2));
      is_main   = (col_ff != '0) && (row_ff != '0);
      last_tick = (col_ff == '0) && (row_ff == h_plus1);

      col_in = col_ff;
      row_in = row_ff;
      if (csr_write_en) begin
         col_in = '0;
         row_in = '0;
      end else if (take) begin
         if (last_tick) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + gbl_pkg::ROW_W'(1);
         end else begin
            col_in = col_wide[gbl_pkg::COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // neighbourhood borders: right-edge pixel of two rows up, or the pixel
   // one row up and one column left
   always_comb begin
      s1_in.pix              = drain_row ? '0 : req_data.pixel_in;
      s1_in.col              = col_ff;
      s1_in.row_ge1          = row_ff != '0;
      s1_in.row_ge2          = row_ff >= gbl_pkg::ROW_W'(2);
      s1_in.emit             = is_edge || is_main;
      s1_in.last             = last_tick;
      s1_in.border.top_out   = is_edge ? (row_ff == gbl_pkg::ROW_W'(2))
                                       : (row_ff == gbl_pkg::ROW_W'(1));
      s1_in.border.bot_out   = is_edge ? (row_ff >= h_plus1) : drain_row;
      s1_in.border.left_out  = is_edge ? (width_ff == gbl_pkg::WIDTH_REG_W'(1))
                                       : (col_ff == gbl_pkg::COL_W'(1));
      s1_in.border.right_out = is_edge;
   end

   // ---------------- stage 1: line store read ----------------
   gbl_line_store u_line_store (
      .clock   (clock),
      .wr_en   (shift_en),
      .wr_addr (s1_ff.col),
      .wr_data (wr_data),
      .rd_en   (adv),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      line_a       = fwd_ff ? fwd_data_ff.above1 : rd_data.above1;
      line_b       = fwd_ff ? fwd_data_ff.above2 : rd_data.above2;
      new_col.top  = s1_ff.row_ge2 ? line_b : '0;
      new_col.mid  = s1_ff.row_ge1 ? line_a : '0;
      new_col.bot  = s1_ff.pix;
      wr_data.above2 = new_col.mid;
      wr_data.above1 = s1_ff.pix;
      shift_en     = adv && s1_valid_ff;
      // read and write of one entry at the same edge: pass the write data on
      fwd_in       = take && s1_valid_ff && (col_ff == s1_ff.col);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= take;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff       <= s1_in;
         fwd_data_ff <= wr_data;
      end
   end

   // ---------------- window cells ----------------
   gbl_col_cell u_cell_centre (
      .clock    (clock),
      .reset    (reset),
      .shift_en (shift_en),
      .col_in   (new_col),
      .centre   (centre_nbr.mid),
      .border   (s1_ff.border),
      .col_out  (1'b0),
      .nbr_out  (centre_nbr),
      .tap_out  (centre_tap)
   );

   gbl_col_cell u_cell_left (
      .clock    (clock),
      .reset    (reset),
      .shift_en (shift_en),
      .col_in   (centre_nbr),
      .centre   (centre_nbr.mid),
      .border   (s1_ff.border),
      .col_out  (s1_ff.border.left_out),
      .nbr_out  (left_nbr),
      .tap_out  (left_tap)
   );

   always_comb begin
      nbhd.left   = left_tap;
      nbhd.centre = centre_tap;
      nbhd.right  = gbl_pkg::replace_col(new_col, centre_nbr.mid, s1_ff.border.top_out,
                                         s1_ff.border.bot_out, s1_ff.border.right_out);
   end

   // ---------------- stage 2: neighbourhood register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && s1_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_nbhd_ff <= nbhd;
         s2_last_ff <= s1_ff.last;
      end
   end

   gbl_kernel u_kernel (
      .nbhd    (s2_nbhd_ff),
      .blurred (blurred),
      .changed (changed)
   );

   // ---------------- stage 3: output register ----------------
   always_comb begin
      frame_any        = frame_changed_ff || changed;
      frame_changed_in = frame_changed_ff;
      if (csr_write_en) begin
         frame_changed_in = 1'b0;
      end else if (adv && s2_valid_ff) begin
         frame_changed_in = s2_last_ff ? 1'b0 : frame_any;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         frame_changed_ff <= 1'b0;
      end else begin
         frame_changed_ff <= frame_changed_in;
         if (adv) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.blurred     <= blurred;
         rsp_ff.changed     <= changed;
         rsp_ff.any_changed <= s2_last_ff && frame_any;
         rsp_ff.last        <= s2_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- checks ----------------
   `GBL_ASSERT_ALWAYS(a_col_in_row, clock, reset, {1'b0, col_ff} < width_ff, "column beyond width")
   `GBL_ASSERT_ALWAYS(a_row_bound, clock, reset, row_ff <= h_plus1, "row beyond flush row")
   `GBL_ASSERT_IMPLY(a_any_only_last, clock, reset, rsp_valid_ff && !rsp_ff.last,
      !rsp_ff.any_changed, "frame flag on a result that is not last")
   `GBL_ASSERT_IMPLY(a_last_is_edge, clock, reset, s1_valid_ff && s1_ff.last,
      s1_ff.emit && s1_ff.border.right_out, "frame end not on a right-edge result")

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// self-checking bench for the 3x3 gaussian blur stream: frames of pixels and flush
// ticks go in under random handshakes, every blurred result is predicted and compared
// depends on gbl_pkg and gaussian_blur_3x3_stream_top
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gbl_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 4;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 400;
   localparam int RANDOM_ITEMS   = 1750;
   localparam int WHOLE_FRAME    = 1 << 30;
   localparam int MAX_PRINTED    = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   gaussian_blur_3x3_stream_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // bench state
   req_type pixel_stream [$];
   rsp_type blur_expected [$];
   bit      idle_on = 1'b1;
   bit      long_hold_req = 1'b0;
   bit      long_hold_done = 1'b0;
   int      send_gap = 0;
   int      stall_left = 0;
   int      quiet_cycles = 0;
   int      err_count = 0;
   int      items_taken = 0;
   int      results_seen = 0;
   int      frames_done = 0;
   int      csr_writes = 0;
   int      fed_items = 0;
   rsp_type want_rsp;
   rsp_type next_rsp;

   // blur predictor: line stores, window, positions and its own register copy
   logic [PIX_W-1:0]        prev_row  [MAX_WIDTH];
   logic [PIX_W-1:0]        prev_row2 [MAX_WIDTH];
   logic [PIX_W-1:0]        win [9];
   int unsigned             in_col, in_row, out_index;
   bit                      frame_dirty;
   logic [WIDTH_REG_W-1:0]  cfg_width;
   logic [HEIGHT_REG_W-1:0] cfg_height;

   function automatic int active_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return cfg_width;
   endfunction

   function automatic int active_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   function automatic void rewind_frame();
      in_col = 0;
      in_row = 0;
      out_index = 0;
      frame_dirty = 1'b0;
   endfunction

   function automatic void blur_reset();
      for (int i = 0; i < MAX_WIDTH; i++) begin
         prev_row[i] = '0;
         prev_row2[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      cfg_width = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      rewind_frame();
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      if (idx == CSR_IMAGE_WIDTH) begin
         cfg_width = val[WIDTH_REG_W-1:0];
         rewind_frame();
      end else if (idx == CSR_IMAGE_HEIGHT) begin
         cfg_height = val[HEIGHT_REG_W-1:0];
         rewind_frame();
      end
   endfunction

   // kernel sum over the window around column ccol; outside neighbours take the centre
   function automatic int unsigned blur_at(input int ccol, input int orow, input int ocol,
                                           input int h, input int w);
      int unsigned sum, v, wt;
      int dr, dc, rr, cc, wc;
      sum = 0;
      for (dr = -1; dr <= 1; dr++) begin
         for (dc = -1; dc <= 1; dc++) begin
            rr = orow + dr;
            cc = ocol + dc;
            wc = ccol + dc;
            v = win[3 + ccol];
            wt = (dr == 0 ? 2 : 1) * (dc == 0 ? 2 : 1);
            if (rr >= 0 && rr < h && cc >= 0 && cc < w && wc >= 0 && wc <= 2)
               v = win[(1 + dr) * 3 + wc];
            sum += v * wt;
         end
      end
      return sum / 16;
   endfunction

   function automatic rsp_type make_result(input int unsigned value,
                                           input logic [PIX_W-1:0] centre,
                                           input int unsigned frame_px, output bit fin);
      rsp_type r;
      r.blurred = value[PIX_W-1:0];
      r.changed = (r.blurred != centre);
      frame_dirty |= r.changed;
      fin = (out_index == frame_px - 1);
      r.any_changed = fin ? frame_dirty : 1'b0;
      r.last = fin;
      out_index++;
      return r;
   endfunction

   function automatic bit blur_step(input req_type t, output rsp_type r);
      int unsigned w, h, c, ro, top, mid, p;
      int k;
      bit fin, got;
      w = active_width();
      h = active_height();
      c = in_col;
      ro = in_row;
      fin = 1'b0;
      got = 1'b0;
      r = '0;
      // drains during the pixel rows and pixels during the flush are dropped
      if (ro < h) begin
         if (t.drain) return 1'b0;
         p = t.pixel_in;
      end else begin
         if (!t.drain) return 1'b0;
         p = 0;
      end
      if (c >= w) c = 0;
      mid = (ro >= 1) ? prev_row[c] : 0;
      top = (ro >= 2) ? prev_row2[c] : 0;
      prev_row2[c] = mid;
      prev_row[c] = p;
      // right edge of the row two above, taken before the window shifts
      if (c == 0 && ro >= 2) begin
         r = make_result(blur_at(2, ro - 2, w - 1, h, w), win[5], h * w, fin);
         got = 1'b1;
      end
      for (k = 0; k < 3; k++) begin
         win[k * 3] = win[k * 3 + 1];
         win[k * 3 + 1] = win[k * 3 + 2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = p;
      if (c >= 1 && ro >= 1) begin
         r = make_result(blur_at(1, ro - 1, c - 1, h, w), win[4], h * w, fin);
         got = 1'b1;
      end
      c++;
      if (c >= w) begin
         c = 0;
         ro++;
      end
      in_col = c;
      in_row = ro;
      if (fin) rewind_frame();
      return got;
   endfunction

   task automatic report_error(input string msg);
      if (err_count < MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pixel_stream.size() != 0) begin
            req_data <= pixel_stream.pop_front();
            req_valid <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 12);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: short random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (long_hold_req && !long_hold_done) begin
         rsp_ready <= 1'b0;
         stall_left <= LONG_HOLD;
         long_hold_done <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: check each result transaction, predict from each pixel transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (blur_expected.size() == 0) begin
               report_error($sformatf("result %0d arrived with none expected", results_seen));
            end else begin
               want_rsp = blur_expected.pop_front();
               if (rsp_data.blurred !== want_rsp.blurred)
                  report_error($sformatf("result %0d blurred got %0d want %0d",
                                         results_seen, rsp_data.blurred, want_rsp.blurred));
               if (rsp_data.changed !== want_rsp.changed)
                  report_error($sformatf("result %0d changed got %b want %b",
                                         results_seen, rsp_data.changed, want_rsp.changed));
               if (rsp_data.any_changed !== want_rsp.any_changed)
                  report_error($sformatf("result %0d any_changed got %b want %b", results_seen,
                                         rsp_data.any_changed, want_rsp.any_changed));
               if (rsp_data.last !== want_rsp.last)
                  report_error($sformatf("result %0d last got %b want %b",
                                         results_seen, rsp_data.last, want_rsp.last));
               if (want_rsp.last) frames_done++;
            end
         end
         if (req_valid && req_ready) begin
            items_taken++;
            if (blur_step(req_data, next_rsp)) blur_expected.push_back(next_rsp);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no transaction for %0d cycles, %0d results outstanding",
                  quiet_cycles, blur_expected.size());
         $display("** gaussian_blur_3x3_stream_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic offer(input logic drain, input logic [PIX_W-1:0] value);
      req_type px;
      px.drain = drain;
      px.pixel_in = value;
      pixel_stream.push_back(px);
   endtask

   task automatic wait_results();
      do @(negedge clock);
      while (pixel_stream.size() != 0 || req_valid || blur_expected.size() != 0);
   endtask

   // block idle: results out and the pipeline given time to empty
   task automatic settle();
      wait_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      apply_csr(idx, val);
      csr_writes++;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_size(input int w, input int h);
      logic [CSR_DATA_W-1:0] wv;
      wv = w;
      wv[CSR_DATA_W-1] = $urandom_range(0, 1);
      if ($urandom_range(0, 1)) begin
         write_csr(CSR_IMAGE_WIDTH, wv);
         write_csr(CSR_IMAGE_HEIGHT, h);
      end else begin
         write_csr(CSR_IMAGE_HEIGHT, h);
         write_csr(CSR_IMAGE_WIDTH, wv);
      end
   endtask

   // one frame of pixels then width + 1 flush ticks, cut short after stop items;
   // noise is the percentage of stray transactions the block should drop
   task automatic queue_frame(input int w, input int h, input int noise, input int stop,
                              input int pause_at);
      int total, n, base, mode, v;
      total = w * h + w + 1;
      if (stop > total) stop = total;
      mode = $urandom_range(0, 3);
      base = $urandom_range(0, 255);
      for (n = 0; n < stop; n++) begin
         if (n == pause_at) wait_results();
         if (n < w * h) begin
            if ($urandom_range(0, 99) < noise) offer(1'b1, $urandom_range(0, 255));
            case (mode)
               2: v = base;
               3: begin
                  v = base + $urandom_range(0, 6) - 3;
                  if (v < 0) v = 0;
                  if (v > 255) v = 255;
               end
               default: v = $urandom_range(0, 255);
            endcase
            offer(1'b0, v);
         end else begin
            if (n < total - 1 && $urandom_range(0, 99) < noise)
               offer(1'b0, $urandom_range(0, 255));
            offer(1'b1, $urandom_range(0, 255));
         end
         fed_items++;
      end
      if (stop == total && $urandom_range(0, 99) < noise) offer(1'b1, $urandom_range(0, 255));
   endtask

   initial begin
      int w, h, k, frames, step, aw, ah;
      blur_reset();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset sizes: the top of a 640 x 480 frame, then abandoned
      queue_frame(active_width(), active_height(), 0, 700, -1);
      settle();

      // 3 x 3 checkerboard of extremes with stray ticks in every phase
      write_csr(CSR_IMAGE_WIDTH, 12'd3);
      write_csr(CSR_IMAGE_HEIGHT, 12'd3);
      for (k = 0; k < 9; k++) begin
         if (k == 4) offer(1'b1, 8'h00);
         offer(1'b0, (k % 2 == 0) ? 8'hFF : 8'h00);
      end
      for (k = 0; k < 4; k++) begin
         if (k == 2) offer(1'b0, 8'hA5);
         offer(1'b1, 8'h5A);
      end
      offer(1'b1, 8'h00);
      settle();

      // zero sizes behave as one pixel
      write_csr(CSR_IMAGE_WIDTH, 12'd0);
      write_csr(CSR_IMAGE_HEIGHT, 12'd0);
      offer(1'b0, 8'hFF);
      offer(1'b1, 8'h00);
      offer(1'b1, 8'hFF);
      settle();

      // top data bit lies beyond the width register
      write_csr(CSR_IMAGE_WIDTH, 12'h802);
      write_csr(CSR_IMAGE_HEIGHT, 12'd1);
      offer(1'b0, 8'h00);
      offer(1'b0, 8'hFF);
      repeat (3) offer(1'b1, 8'h00);
      settle();

      // widest line (oversized width clamps) and the tallest frame
      write_csr(CSR_IMAGE_WIDTH, 12'h7FF);
      write_csr(CSR_IMAGE_HEIGHT, 12'd1);
      queue_frame(active_width(), active_height(), 2, WHOLE_FRAME, -1);
      settle();
      write_csr(CSR_IMAGE_WIDTH, 12'd1);
      write_csr(CSR_IMAGE_HEIGHT, 12'hFFF);
      queue_frame(active_width(), active_height(), 2, WHOLE_FRAME, -1);

      fed_items = 0;
      step = 0;
      while (fed_items < RANDOM_ITEMS) begin
         settle();
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 80) : $urandom_range(1, 20);
         h = $urandom_range(1, 12);
         if ($urandom_range(0, 15) == 0) w = 0;
         if ($urandom_range(0, 15) == 0) h = 0;
         if (step == 2) begin
            w = 16;
            h = 24;
         end
         if (step == 5) begin
            w = 12;
            h = 10;
         end
         write_size(w, h);
         aw = active_width();
         ah = active_height();
         frames = $urandom_range(1, 3);
         for (k = 0; k < frames; k++) begin
            // receiver stops taking results while pixels keep coming
            if (step == 2 && k == 0) long_hold_req = 1'b1;
            if (step != 2 && step != 5 && $urandom_range(0, 5) == 0) begin
               queue_frame(aw, ah, 5, $urandom_range(1, aw * ah + aw), -1);
               break;
            end
            // sender stops half way until every result is back
            queue_frame(aw, ah, 5, WHOLE_FRAME, (step == 5 && k == 0) ? (aw * ah) / 2 : -1);
         end
         step++;
      end

      // closing stretch at full rate on both sides
      settle();
      idle_on = 1'b0;
      write_csr(CSR_IMAGE_WIDTH, 12'd9);
      write_csr(CSR_IMAGE_HEIGHT, 12'd7);
      queue_frame(active_width(), active_height(), 0, WHOLE_FRAME, -1);
      queue_frame(active_width(), active_height(), 0, WHOLE_FRAME, -1);

      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run: %0d pixel/flush transactions, %0d results, %0d whole frames, %0d csr writes",
               items_taken, results_seen, frames_done, csr_writes);
      $display("run: sizes 1x1 up to 1024 wide and 4095 tall, long hold-off %0s, %0d mismatches",
               long_hold_done ? "done" : "missed", err_count);
      if (err_count == 0) begin
         $display("** gaussian_blur_3x3_stream_top: PASSED **");
      end else begin
         $display("** gaussian_blur_3x3_stream_top: FAILED **");
      end
      $finish;
   end

endmodule
